/* sv/nsd_pkg.sv */
package nsd_pkg;

  localparam int unsigned MaxSpheres = 256;
  localparam int unsigned IdxW = $clog2(MaxSpheres);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW = 31;
  localparam int unsigned DistW = 34;
  localparam int unsigned SqW = 66;
  localparam int unsigned RootW = 34;
  localparam int unsigned EntryW = 3 * CoordW + RadW;

  typedef enum logic [1:0] {
    ActWrite   = 2'd0,
    ActSurface = 2'd1,
    ActCenter  = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [RadW-1:0]   r;
  } entry_t;

endpackage

/* sv/nsd_ram.sv */
module nsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/nsd_sqrt.sv */
module nsd_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nsd_pkg::SqW-1:0]   rad_i,
  output logic                      done_o,
  output logic [nsd_pkg::RootW-1:0] root_o
);
  import nsd_pkg::*;

  localparam int unsigned StepW = $clog2(RootW + 1);

  logic [SqW-1:0]   rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SqW+1:0]   trial;
  logic [SqW-1:0]   bits_q, bits_d;
  logic [SqW+1:0]   rem_sh;

  // Restoring square root, one result bit each cycle, two radicand bits in.
  // The radicand holds SqW/2 bit pairs, so that many steps give the root.
  always_comb begin
    rem_sh = {rem_q, bits_q[SqW-1 -: 2]};
    trial  = rem_sh - {{(SqW-RootW){1'b0}}, root_q, 2'b01};
    rem_d  = rem_q;
    root_d = root_q;
    bits_d = bits_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      bits_d = rad_i;
      step_d = StepW'(SqW / 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[SqW+1]) begin
        rem_d  = trial[SqW-1:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[SqW-1:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      bits_d = {bits_q[SqW-3:0], 2'b00};
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bits_q <= bits_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* sv/nearest_sphere_distance.sv */
// Nearest sphere distance unit. Write items store one sphere in a 256-entry
// table RAM and leave the sequencer idle. A query reads entries one at a time;
// each entry passes through the read state, a state squaring the coordinate
// differences, one forming their sum and the bit-serial square root state,
// which waits for the root's 33 iterations and its done strobe. No new item
// is taken while a query searches the table. A query on an empty table answers
// on the next cycle. The result waits in an output register, and no further
// item is taken until it has been accepted.
module nearest_sphere_distance (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [8:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [7:0]                  entry_index_i,
  input  logic signed [31:0]          coord_x_i,
  input  logic signed [31:0]          coord_y_i,
  input  logic signed [31:0]          coord_z_i,
  input  logic [30:0]                 sphere_radius_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [33:0]          min_distance_o,
  output logic [7:0]                  nearest_index_o,
  output logic                        table_empty_o
);
  import nsd_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRead, StSquare, StSum, StRoot, StDone
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   lim_q;
  logic [CntW-1:0]   idx_q;
  logic              surf_q;
  logic [CoordW-1:0] px_q, py_q, pz_q;
  logic [32:0]       dx_q, dy_q, dz_q;
  logic [SqW-1:0]    sx_q, sy_q, sz_q;
  logic [SqW-1:0]    sq_sum;
  logic [RadW-1:0]   rad_q;
  logic signed [DistW-1:0] best_q;
  logic [IdxW-1:0]   best_i_q;
  logic              out_valid_q;
  logic              out_valid_d;
  logic signed [DistW-1:0] res_d_q;
  logic [IdxW-1:0]   res_i_q;
  logic              res_e_q;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [IdxW-1:0]   rd_addr;
  logic              we;
  logic              sq_start;
  logic              sq_done;
  logic [RootW-1:0]  root;
  logic signed [DistW:0] cand_dist;
  logic [RootW-1:0]  root_sat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle) && !(out_valid_q && !out_ready_i);

  assign we = in_valid_i && in_ready_o && (action_i == ActWrite);
  assign wr_entry = '{x: coord_x_i, y: coord_y_i, z: coord_z_i, r: sphere_radius_i};

  // Read address: entry zero while idle, the next entry as one finishes, so
  // that the registered read data is ready in the read state.
  always_comb begin
    rd_addr = idx_q[IdxW-1:0];
    if (state_q == StIdle) begin
      rd_addr = '0;
    end else if (state_q == StRoot && sq_done) begin
      rd_addr = idx_q[IdxW-1:0] + IdxW'(1);
    end
  end

  nsd_ram #(.Width(EntryW), .Depth(MaxSpheres)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (entry_index_i),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  // Sum of the squares, taken by the square root unit as it starts.
  assign sq_sum   = sx_q + sy_q + sz_q;
  assign sq_start = (state_q == StSum);

  nsd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_sum),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // Saturate the centre distance, then take off the radius in surface mode.
  always_comb begin
    root_sat = (root > RootW'(34'h1FFFFFFFF)) ? RootW'(34'h1FFFFFFFF) : root;
    cand_dist = $signed({1'b0, root_sat});
    if (surf_q) begin
      cand_dist = cand_dist - $signed({4'b0, rad_q});
    end
  end

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : d;
  endfunction

  // A result is raised for a query on an empty table or at the end of a
  // search, and held until it is accepted.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == StIdle && in_valid_i && in_ready_o &&
        (action_i == ActSurface || action_i == ActCenter) && count_q == '0) begin
      out_valid_d = 1'b1;
    end
    if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
    end
  end

  // Control sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      unique case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (in_valid_i && in_ready_o &&
              (action_i == ActSurface || action_i == ActCenter) &&
              count_q != '0) begin
            state_q <= StRead;
          end
        end
        StRead:   state_q <= StSquare;
        StSquare: state_q <= StSum;
        StSum:    state_q <= StRoot;
        StRoot: begin
          if (sq_done) begin
            if (idx_q + 1'b1 >= lim_q) begin
              state_q <= StDone;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= StRead;
            end
          end
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) begin
      px_q   <= coord_x_i;
      py_q   <= coord_y_i;
      pz_q   <= coord_z_i;
      surf_q <= (action_i == ActSurface);
      lim_q  <= (count_q > CntW'(MaxSpheres)) ? CntW'(MaxSpheres) : count_q;
      res_d_q <= '0;
      res_i_q <= '0;
      res_e_q <= 1'b1;
    end
    if (state_q == StRead) begin
      dx_q  <= absd(px_q, rd_entry.x);
      dy_q  <= absd(py_q, rd_entry.y);
      dz_q  <= absd(pz_q, rd_entry.z);
      rad_q <= rd_entry.r;
    end
    if (state_q == StSquare) begin
      sx_q <= SqW'(dx_q) * SqW'(dx_q);
      sy_q <= SqW'(dy_q) * SqW'(dy_q);
      sz_q <= SqW'(dz_q) * SqW'(dz_q);
    end
    if (state_q == StRoot && sq_done) begin
      if (idx_q == '0 || DistW'(cand_dist) < best_q) begin
        best_q   <= DistW'(cand_dist);
        best_i_q <= idx_q[IdxW-1:0];
      end
    end
    if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
      res_d_q <= best_q;
      res_i_q <= best_i_q;
      res_e_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign min_distance_o  = res_d_q;
  assign nearest_index_o = res_i_q;
  assign table_empty_o   = res_e_q;

endmodule

/* test/nearest_sphere_distance_tb.sv */
module nearest_sphere_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsd_pkg::*;

  localparam int unsigned CycleLimit = 10000000;
  localparam longint DistMax = 64'd8589934591;

  // One expected query answer.
  typedef struct {
    logic signed [33:0] distance;
    logic [7:0]         index;
    logic               empty;
  } answer_t;

  // Shadow of the sphere table and the predicted answers still to arrive.
  class sphere_scoreboard;
    logic [31:0] cx[MaxSpheres];
    logic [31:0] cy[MaxSpheres];
    logic [31:0] cz[MaxSpheres];
    logic [30:0] rad[MaxSpheres];
    int unsigned count;
    answer_t     answers[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      count = 0;
      errors = 0;
      checked = 0;
    endfunction

    function automatic logic [33:0] trunc_root(logic [65:0] s);
      logic [33:0] r;
      logic [33:0] t;
      logic [67:0] sq;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        t = r | (34'd1 << b);
        sq = 68'(t) * 68'(t);
        if (sq <= 68'(s)) r = t;
      end
      return r;
    endfunction

    function automatic longint centre_dist(int i, logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
      logic [65:0] acc;
      logic [63:0] ad;
      longint d;
      longint r;
      logic [31:0] p[3];
      logic [31:0] c[3];
      p = '{px, py, pz};
      c = '{cx[i], cy[i], cz[i]};
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        d = longint'($signed(p[k])) - longint'($signed(c[k]));
        ad = (d < 0) ? -d : d;
        acc = acc + 66'(ad) * 66'(ad);
      end
      r = longint'(trunc_root(acc));
      if (r > DistMax) r = DistMax;
      return r;
    endfunction

    function void set_count(int unsigned v);
      count = v;
    endfunction

    // Accepted input item: either update the table or predict a query answer.
    function void note_item(action_e act, logic [7:0] idx, logic [31:0] px,
                            logic [31:0] py, logic [31:0] pz, logic [30:0] r);
      answer_t a;
      int unsigned n;
      longint cand;
      longint best;
      int best_i;
      best = 0;
      best_i = 0;
      if (act == ActWrite) begin
        cx[idx] = px;
        cy[idx] = py;
        cz[idx] = pz;
        rad[idx] = r;
        return;
      end
      if (act == ActNone) return;
      n = (count > MaxSpheres) ? MaxSpheres : count;
      if (n == 0) begin
        a.distance = '0;
        a.index = '0;
        a.empty = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          cand = centre_dist(i, px, py, pz);
          if (act == ActSurface) cand -= longint'(rad[i]);
          if (i == 0 || cand < best) begin
            best = cand;
            best_i = i;
          end
        end
        a.distance = best[33:0];
        a.index = best_i[7:0];
        a.empty = 1'b0;
      end
      answers = {answers, a};
    endfunction

    // Accepted result item against the oldest prediction.
    function void check_result(logic [33:0] got_dist, logic [7:0] idx, logic empty);
      answer_t a;
      checked++;
      if (answers.size() == 0) begin
        $error("result item with no query outstanding");
        errors++;
        return;
      end
      a = answers.pop_front();
      if (got_dist !== a.distance) begin
        $error("min_distance: expected %0d, got %0d", a.distance, $signed(got_dist));
        errors++;
      end
      if (idx !== a.index) begin
        $error("nearest_index: expected %0d, got %0d", a.index, idx);
        errors++;
      end
      if (empty !== a.empty) begin
        $error("table_empty: expected %0b, got %0b", a.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [8:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic [7:0]         entry_index_i;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_y_i;
  logic signed [31:0] coord_z_i;
  logic [30:0]        sphere_radius_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [33:0] min_distance_o;
  logic [7:0]         nearest_index_o;
  logic               table_empty_o;

  sphere_scoreboard sb = new();
  bit               no_gaps;
  bit               held_off;
  int unsigned      cycles;

  nearest_sphere_distance u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .entry_index_i   (entry_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .sphere_radius_i (sphere_radius_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .min_distance_o  (min_distance_o),
    .nearest_index_o (nearest_index_o),
    .table_empty_o   (table_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor: note accepted items and check results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_item(action_e'(action_i), entry_index_i, coord_x_i, coord_y_i,
                   coord_z_i, sphere_radius_i);
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.set_count(cfg_data_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(min_distance_o, nearest_index_o, table_empty_o);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("nearest_sphere_distance_tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, with one long hold-off so that the block backs up.
  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = no_gaps ? 0 : $urandom_range(0, 18);
      if (!held_off && sb.checked >= 150) begin
        held_off = 1'b1;
        n = 600;
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Offer one input item and hold it until it is accepted.
  task automatic send_item(action_e act, logic [7:0] idx, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [30:0] r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    entry_index_i   <= idx;
    coord_x_i       <= x;
    coord_y_i       <= y;
    coord_z_i       <= z;
    sphere_radius_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Let the block drain, then write the sphere count.
  task automatic write_count(logic [8:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 4095) - 2048;
      3:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0:       return 31'h7FFF_FFFF;
      1:       return 31'($urandom_range(0, 32'h0008_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic rand_item();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6)
      send_item(ActWrite, 8'($urandom), rand_coord(), rand_coord(), rand_coord(),
                rand_radius());
    else if (pick == 6)
      send_item(ActNone, 8'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
    else
      send_item(pick < 13 ? ActSurface : ActCenter, 8'($urandom), rand_coord(),
                rand_coord(), rand_coord(), 31'($urandom));
  endtask

  // Stimulus.
  initial begin
    int unsigned sent;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    action_i        = ActNone;
    entry_index_i   = '0;
    coord_x_i       = '0;
    coord_y_i       = '0;
    coord_z_i       = '0;
    sphere_radius_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table gives the flag on both query kinds.
    write_count(9'd0);
    send_item(ActSurface, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 31'd5);
    send_item(ActCenter, 8'd255, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);

    // Fill every entry so that no query reads an unwritten one.
    for (int i = 0; i < MaxSpheres; i++)
      send_item(ActWrite, i[7:0], rand_coord(), rand_coord(), rand_coord(),
                rand_radius());

    // Extreme centres, widest radius and a tie between two equal entries.
    send_item(ActWrite, 8'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              31'h7FFF_FFFF);
    send_item(ActWrite, 8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    send_item(ActWrite, 8'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    write_count(9'd3);
    send_item(ActCenter, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    send_item(ActSurface, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    send_item(ActCenter, 8'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
    send_item(ActSurface, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
    send_item(ActNone, 8'd3, 32'd1, 32'd2, 32'd3, 31'd4);
    send_item(ActSurface, 8'd0, 32'd0, 32'd0, 32'd0, 31'd0);

    // Counts above the table size clamp to the full table.
    write_count(9'h1FF);
    send_item(ActSurface, 8'd0, 32'd0, 32'd0, 32'd0, 31'd0);
    write_count(9'd256);
    send_item(ActCenter, 8'd0, 32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF, 31'd0);

    // Random phases, mostly over short tables to keep queries quick.
    sent = 0;
    while (sent < 1000) begin
      case ($urandom_range(0, 9))
        0:       write_count(9'($urandom_range(9, 40)));
        1:       write_count(9'd1);
        default: write_count(9'($urandom_range(1, 8)));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 45; k++) rand_item();
      sent += 45;
      no_gaps = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("nearest_sphere_distance_tb: clean");
    end else begin
      $display("nearest_sphere_distance_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/nsd_pkg.sv
sv/nsd_ram.sv
sv/nsd_sqrt.sv
sv/nearest_sphere_distance.sv
test/nearest_sphere_distance_tb.sv
